>>> rtl/convex_hull_monotone_chain_macros.svh
// Assertion macros shared by the convex hull block.
// No dependencies; included inside module bodies that check their own logic.
`ifndef CONVEX_HULL_MONOTONE_CHAIN_MACROS_SVH
`define CONVEX_HULL_MONOTONE_CHAIN_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define CHMC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("convex hull: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define CHMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("convex hull: next-cycle check failed");

`endif

>>> rtl/chmc_pkg.sv
// Package for the convex hull block: default sizes.
// No dependencies; used by convex_hull_monotone_chain.
package chmc_pkg;

  localparam int MAX_POINTS_DEF = 32;
  localparam int COORD_BITS_DEF = 16;

endpackage

>>> rtl/convex_hull_monotone_chain.sv
// Convex hull of a point set by the monotone chain method, one module.
// Depends on chmc_pkg and convex_hull_monotone_chain_macros.svh.
//
// Points are taken one per cycle and held in a point memory; the request
// marked last_point starts the hull. The memory is then insertion-sorted in
// place, and the lower and upper chains are built with the hull kept in a
// second memory, each turn test being a cross product taken in a difference,
// a multiply and a compare step. Each vertex is then read from the hull
// memory, registered onto the outputs and held there while out_stall is high.
// Both memories have one read and one write port with a registered read,
// and that read port paces the sort and the chains. No input is taken from
// the last_point request until the closing vertex has been delivered.
module convex_hull_monotone_chain #(
  parameter int MAX_POINTS = chmc_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = chmc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  input  logic                         last_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] vertex_x,
  output logic signed [COORD_BITS-1:0] vertex_y,
  output logic                         last_vertex,
  output logic                         overflow
);
  import chmc_pkg::*;
  `include "convex_hull_monotone_chain_macros.svh"

  localparam int CB = COORD_BITS;
  localparam int WW = 2 * CB;
  localparam int HD = MAX_POINTS + 1;
  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int HW = $clog2(HD);
  localparam int JW = $clog2(HD + 1);
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SKEY, ST_SKEYW, ST_SCMP, ST_SPUT,
    ST_HRD, ST_HLD, ST_HCHK, ST_HDIFF, ST_HMUL, ST_HCMP, ST_HPOPW,
    ST_ORD, ST_OLD, ST_OUT
  } state_t;

  state_t state;

  logic [WW-1:0] pmem [MAX_POINTS];
  logic [WW-1:0] hmem [HD];
  logic [WW-1:0] prd, hrd;

  logic          p_we;
  logic [IW-1:0] p_waddr, p_raddr;
  logic [WW-1:0] p_wdata;
  logic          h_we;
  logic [HW-1:0] h_waddr, h_raddr;

  logic [CW-1:0] cnt;
  logic          ovf;
  logic [IW-1:0] si, sj, hi;
  logic [WW-1:0] key, a, t1, t2;
  logic          upper;
  logic [JW-1:0] j, base, k;
  logic signed [DW-1:0] d0, d1, d2, d3;
  logic signed [PW-1:0] lhs, rhs;

  logic signed [CB-1:0] kx, ky, px, py, ax, ay, t1x, t1y, t2x, t2y;
  logic          key_before, room_p, pop_ok, cross_pop, do_push, room_h;
  logic [CW-1:0] cnt_inc;
  logic [IW-1:0] last_idx;

  assign kx  = signed'(key[WW-1:CB]);
  assign ky  = signed'(key[CB-1:0]);
  assign px  = signed'(prd[WW-1:CB]);
  assign py  = signed'(prd[CB-1:0]);
  assign ax  = signed'(a[WW-1:CB]);
  assign ay  = signed'(a[CB-1:0]);
  assign t1x = signed'(t1[WW-1:CB]);
  assign t1y = signed'(t1[CB-1:0]);
  assign t2x = signed'(t2[WW-1:CB]);
  assign t2y = signed'(t2[CB-1:0]);

  assign key_before = (kx < px) || ((kx == px) && (ky < py));
  assign room_p     = cnt < CW'(MAX_POINTS);
  assign cnt_inc    = room_p ? cnt + CW'(1) : cnt;
  assign last_idx   = IW'(cnt - CW'(1));
  assign pop_ok     = upper ? (j > base) : (j > JW'(1));
  assign cross_pop  = lhs >= rhs;
  assign do_push    = ((state == ST_HCHK) && !pop_ok) || ((state == ST_HCMP) && !cross_pop);
  assign room_h     = j < JW'(HD);
  assign in_stall   = (state != ST_LOAD);

  always_comb begin
    p_we    = 1'b0;
    p_waddr = sj;
    p_wdata = key;
    p_raddr = si;
    h_we    = do_push && room_h;
    h_waddr = HW'(j);
    h_raddr = HW'(k);
    case (state)
      ST_LOAD: begin
        p_we    = in_valid && room_p;
        p_waddr = IW'(cnt);
        p_wdata = {point_x, point_y};
      end
      ST_SKEYW: p_raddr = sj - IW'(1);
      ST_SCMP: begin
        p_we    = 1'b1;
        p_wdata = key_before ? prd : key;
        p_raddr = sj - IW'(2);
      end
      ST_SPUT: begin
        p_we    = 1'b1;
        p_waddr = '0;
      end
      ST_HRD:  p_raddr = hi;
      ST_HCMP: h_raddr = HW'(j - JW'(3));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (p_we) begin
      pmem[p_waddr] <= p_wdata;
    end
    prd <= pmem[p_raddr];
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hmem[h_waddr] <= a;
    end
    hrd <= hmem[h_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      cnt       <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (in_valid) begin
            cnt <= cnt_inc;
            if (!room_p) begin
              ovf <= 1'b1;
            end
            if (last_point) begin
              si    <= IW'(1);
              hi    <= '0;
              j     <= '0;
              upper <= 1'b0;
              state <= (cnt_inc >= CW'(2)) ? ST_SKEY : ST_HRD;
            end
          end
        end
        ST_SKEY: begin
          sj    <= si;
          state <= ST_SKEYW;
        end
        ST_SKEYW: begin
          key   <= prd;
          state <= ST_SCMP;
        end
        ST_SCMP: begin
          if (key_before) begin
            sj <= sj - IW'(1);
            if (sj == IW'(1)) begin
              state <= ST_SPUT;
            end
          end else if (CW'(si) + CW'(1) == cnt) begin
            state <= ST_HRD;
          end else begin
            si    <= si + IW'(1);
            state <= ST_SKEY;
          end
        end
        ST_SPUT: begin
          if (CW'(si) + CW'(1) == cnt) begin
            state <= ST_HRD;
          end else begin
            si    <= si + IW'(1);
            state <= ST_SKEY;
          end
        end
        ST_HRD:  state <= ST_HLD;
        ST_HLD: begin
          a     <= prd;
          state <= ST_HCHK;
        end
        ST_HCHK: begin
          if (pop_ok) begin
            state <= ST_HDIFF;
          end
        end
        ST_HDIFF: begin
          d0    <= DW'(t2y) - DW'(ay);
          d1    <= DW'(t1x) - DW'(ax);
          d2    <= DW'(t2x) - DW'(ax);
          d3    <= DW'(t1y) - DW'(ay);
          state <= ST_HMUL;
        end
        ST_HMUL: begin
          lhs   <= d0 * d1;
          rhs   <= d2 * d3;
          state <= ST_HCMP;
        end
        ST_HCMP: begin
          if (cross_pop) begin
            j     <= j - JW'(1);
            t1    <= t2;
            state <= ST_HPOPW;
          end
        end
        ST_HPOPW: begin
          t2    <= hrd;
          state <= ST_HCHK;
        end
        ST_ORD:  state <= ST_OLD;
        ST_OLD: begin
          vertex_x    <= signed'(hrd[WW-1:CB]);
          vertex_y    <= signed'(hrd[CB-1:0]);
          last_vertex <= (k + JW'(1) == j);
          overflow    <= ovf;
          out_valid   <= 1'b1;
          state       <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_vertex) begin
              cnt   <= '0;
              ovf   <= 1'b0;
              state <= ST_LOAD;
            end else begin
              k     <= k + JW'(1);
              state <= ST_ORD;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase

      if (do_push) begin
        if (room_h) begin
          j  <= j + JW'(1);
          t1 <= a;
          t2 <= t1;
        end
        state <= ST_HRD;
        if (!upper) begin
          if (hi == last_idx) begin
            base <= room_h ? j + JW'(1) : j;
            if (cnt == CW'(1)) begin
              k     <= '0;
              state <= ST_ORD;
            end else begin
              upper <= 1'b1;
              hi    <= last_idx - IW'(1);
            end
          end else begin
            hi <= hi + IW'(1);
          end
        end else if (hi == '0) begin
          k     <= '0;
          state <= ST_ORD;
        end else begin
          hi <= hi - IW'(1);
        end
      end
    end
  end

  `CHMC_ASSERT_NOW(a_cnt_bound, clk, rst, 1'b1, cnt <= CW'(MAX_POINTS))
  `CHMC_ASSERT_NOW(a_out_state, clk, rst, out_valid, state == ST_OUT)
  `CHMC_ASSERT_NOW(a_chain_floor, clk, rst, (state == ST_HCHK) && upper, j >= base)
  `CHMC_ASSERT_NEXT(a_set_cleared, clk, rst, out_valid && !out_stall && last_vertex,
                    (cnt == '0) && !ovf && (state == ST_LOAD))

endmodule
